// ===== rtl/rgbads_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbads_pkg
// Shared constants and types for the half-size RGBA box downsampler.
// ----------------------------------------------------------------------------
package rgbads_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    localparam int SIZE_W     = 11;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int PAIR_SLOTS = MAX_WIDTH / 2;
    localparam int SLOT_W     = $clog2(PAIR_SLOTS);

    localparam int CHAN_W     = 8;
    localparam int NUM_CHAN   = 4;
    localparam int PIX_W      = CHAN_W * NUM_CHAN;
    localparam int PSUM_W     = CHAN_W + 1;
    localparam int SUMS_W     = PSUM_W * NUM_CHAN;

    typedef logic [SIZE_W-1:0] t_size;
    typedef logic [PIX_W-1:0]  t_pix;
    typedef logic [SUMS_W-1:0] t_sums;

    typedef enum logic [0:0] {
        CFG_IMAGE_WIDTH  = 1'b0,
        CFG_IMAGE_HEIGHT = 1'b1
    } t_cfg_idx;

    localparam t_size SIZE_RESET = t_size'(256);
    localparam t_size SIZE_MIN   = t_size'(2);

    function automatic t_size clamp_size(input t_size v, input t_size hi);
        t_size r;
        if (v < SIZE_MIN) begin
            r = SIZE_MIN;
        end else if (v > hi) begin
            r = hi;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

// ===== rtl/rgba_half_size_box_downsample.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgba_half_size_box_downsample
// Half-size mip level of an RGBA8 raster image, 2x2 truncated box mean.
// ----------------------------------------------------------------------------
// Pixels enter on the s_axis channel in raster order, one transfer per pixel,
// red in the lowest byte. Results leave on m_axis, one per 2x2 block, after
// the lower-right pixel of the block; m_axis_tlast marks the last result of
// the half-size image, after which the position counters start a new image.
// Odd last columns and rows are taken and dropped.
// The cfg channel writes image_width (index 0) and image_height (index 1);
// it is always ready and must be written only while no pixel is in flight
// (the block does not enforce this). Throughput is one pixel per cycle unless
// the output stalls: upper-row pair sums go to a line store of 512 x 36
// bits with one write or one read per pixel, so there is no port conflict.
// A result passes the line store read, then the sum and output register.
// When the receiver stalls, the output register and one stage behind it
// fill, then s_axis_tready drops until the output drains.
// Reset clears counters, sizes (256 x 256) and valid flags; the line store
// holds no reset value and needs no clearing pass.
// ----------------------------------------------------------------------------
module rgba_half_size_box_downsample (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // red_in, green_in, blue_in, alpha_in
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // red_out, green_out, blue_out, alpha_out
    output logic        m_axis_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_addr,
    input  logic [10:0] i_cfg_data
);

    rgbads_pkg::t_size r_width;
    rgbads_pkg::t_size r_height;
    rgbads_pkg::t_size w_eff;
    rgbads_pkg::t_size h_eff;
    logic [rgbads_pkg::SIZE_W-2:0] half_w;
    logic [rgbads_pkg::SIZE_W-2:0] half_h;

    logic [rgbads_pkg::COL_W-1:0]  r_col;
    logic [rgbads_pkg::ROW_W-1:0]  r_row;
    logic [rgbads_pkg::COL_W-1:0]  n_col;
    logic [rgbads_pkg::ROW_W-1:0]  n_row;
    rgbads_pkg::t_pix              r_left;

    logic [rgbads_pkg::SUMS_W-1:0] r_mem [rgbads_pkg::PAIR_SLOTS];
    rgbads_pkg::t_sums             r_rd;

    logic                          r_s1_vld;
    logic                          r_s1_last;
    rgbads_pkg::t_sums             r_s1_sums;

    logic                          r_out_vld;
    logic                          r_out_last;
    rgbads_pkg::t_pix              r_out_data;
    rgbads_pkg::t_pix              n_out_data;

    logic                          in_acc;
    logic                          s1_adv;
    logic                          in_box;
    logic                          col_odd;
    logic                          row_odd;
    logic                          blk_last;
    logic [rgbads_pkg::SLOT_W-1:0] slot;
    rgbads_pkg::t_sums             sums;

    assign o_cfg_ready = 1'b1;

    assign w_eff  = rgbads_pkg::clamp_size(r_width,  rgbads_pkg::t_size'(rgbads_pkg::MAX_WIDTH));
    assign h_eff  = rgbads_pkg::clamp_size(r_height, rgbads_pkg::t_size'(rgbads_pkg::MAX_HEIGHT));
    assign half_w = w_eff[rgbads_pkg::SIZE_W-1:1];
    assign half_h = h_eff[rgbads_pkg::SIZE_W-1:1];

    assign s1_adv        = r_s1_vld && (!r_out_vld || m_axis_tready);
    assign s_axis_tready = !r_s1_vld || !r_out_vld || m_axis_tready;
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    assign in_box  = (rgbads_pkg::t_size'(r_col) < {half_w, 1'b0})
                  && (rgbads_pkg::t_size'(r_row) < {half_h, 1'b0});
    assign col_odd = r_col[0];
    assign row_odd = r_row[0];
    assign slot    = r_col[rgbads_pkg::COL_W-1:1];

    assign blk_last = (rgbads_pkg::t_size'(slot) == rgbads_pkg::t_size'(half_w) - 1'b1)
                   && (rgbads_pkg::t_size'(r_row[rgbads_pkg::ROW_W-1:1])
                       == rgbads_pkg::t_size'(half_h) - 1'b1);

    always_comb begin
        for (int c = 0; c < rgbads_pkg::NUM_CHAN; c++) begin
            sums[c*rgbads_pkg::PSUM_W +: rgbads_pkg::PSUM_W] =
                {1'b0, r_left[c*rgbads_pkg::CHAN_W +: rgbads_pkg::CHAN_W]}
              + {1'b0, s_axis_tdata[c*rgbads_pkg::CHAN_W +: rgbads_pkg::CHAN_W]};
        end
    end

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (rgbads_pkg::t_size'(r_col) + 1'b1 >= w_eff) begin
            n_col = '0;
            if (rgbads_pkg::t_size'(r_row) + 1'b1 >= h_eff) begin
                n_row = '0;
            end else begin
                n_row = r_row + 1'b1;
            end
        end else begin
            n_col = r_col + 1'b1;
        end
    end

    always_comb begin
        for (int c = 0; c < rgbads_pkg::NUM_CHAN; c++) begin
            logic [rgbads_pkg::PSUM_W:0] tot;
            tot = {1'b0, r_rd[c*rgbads_pkg::PSUM_W +: rgbads_pkg::PSUM_W]}
                + {1'b0, r_s1_sums[c*rgbads_pkg::PSUM_W +: rgbads_pkg::PSUM_W]};
            n_out_data[c*rgbads_pkg::CHAN_W +: rgbads_pkg::CHAN_W] =
                tot[rgbads_pkg::PSUM_W:2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= rgbads_pkg::SIZE_RESET;
            r_height <= rgbads_pkg::SIZE_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (rgbads_pkg::t_cfg_idx'(i_cfg_addr))
                rgbads_pkg::CFG_IMAGE_WIDTH:  r_width  <= i_cfg_data;
                rgbads_pkg::CFG_IMAGE_HEIGHT: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_left <= '0;
        end else if (in_acc) begin
            r_col <= n_col;
            r_row <= n_row;
            if (in_box && !col_odd) begin
                r_left <= s_axis_tdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && in_box && col_odd && !row_odd) begin
            r_mem[slot] <= sums;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && in_box && col_odd && row_odd) begin
            r_rd <= r_mem[slot];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (in_acc && in_box && col_odd && row_odd) begin
            r_s1_vld <= 1'b1;
        end else if (s1_adv) begin
            r_s1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && in_box && col_odd && row_odd) begin
            r_s1_sums <= sums;
            r_s1_last <= blk_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s1_adv) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_data <= n_out_data;
            r_out_last <= r_s1_last;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;

endmodule

// ===== rtl/rgbads_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbads_chk
// Port-level checks for the half-size RGBA box downsampler.
// ----------------------------------------------------------------------------
module rgbads_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    logic s_xfer;

    assign s_xfer = s_axis_tvalid && s_axis_tready;

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled output changed");

    a_out_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(s_xfer, 2))
        else $error("output without input transfer two cycles before");

    a_stall_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled while output free");

endmodule

bind rgba_half_size_box_downsample rgbads_chk u_rgbads_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
